[rtl/mrle_pkg.sv]
// Shared types and constants of the marked run-length encoder.
package mrle_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MARK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN = 2'd1;

	localparam logic [7:0] MARK_RESET     = 8'd42;
	localparam logic [7:0] MAX_RUN_RESET  = 8'd207;
	localparam logic [7:0] RUN_LIMIT_CAP  = 8'd207;
	localparam logic [7:0] RUN_DIGIT_BASE = 8'd48;

	// One flush command: run A (length 1 is a literal), then an optional literal B.
	typedef struct packed {
		logic [7:0] a_len;
		logic [7:0] a_byte;
		logic       b_valid;
		logic [7:0] b_byte;
		logic       eos;
	} mrle_cmd_t;

endpackage

[rtl/mrle_front.sv]
// Front end: accepts input beats, tracks the pending run, issues flush commands.
module mrle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                end_of_stream,
	input  logic [7:0]          max_run,
	output logic                push,
	output mrle_pkg::mrle_cmd_t push_cmd,
	input  logic                q_full
);
	import mrle_pkg::*;

	logic [7:0] held_q;
	logic [7:0] len_q;
	logic [7:0] limit;
	logic       accept;
	logic       cont;
	logic       brk;
	logic [7:0] new_len;

	assign limit    = (max_run > RUN_LIMIT_CAP) ? RUN_LIMIT_CAP : max_run;
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign cont    = (len_q != 8'd0) && (data_byte == held_q) && (len_q < limit);
	assign brk     = !cont && (len_q != 8'd0);
	assign new_len = cont ? len_q + 8'd1 : 8'd1;

	assign push = accept && (brk || end_of_stream);

	always_comb begin
		push_cmd.eos    = end_of_stream;
		push_cmd.b_byte = data_byte;
		if (brk) begin
			push_cmd.a_len   = len_q;
			push_cmd.a_byte  = held_q;
			push_cmd.b_valid = end_of_stream;
		end else begin
			push_cmd.a_len   = new_len;
			push_cmd.a_byte  = data_byte;
			push_cmd.b_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'd0;
			len_q  <= 8'd0;
		end else if (accept) begin
			held_q <= data_byte;
			len_q  <= end_of_stream ? 8'd0 : new_len;
		end
	end

endmodule

[rtl/mrle_queue.sv]
// Command queue between front and back; DEPTH must be a power of two.
module mrle_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mrle_pkg::mrle_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output mrle_pkg::mrle_cmd_t head_cmd
);
	import mrle_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mrle_cmd_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not follow push");
`endif

endmodule

[rtl/mrle_back.sv]
// Back end: expands flush commands into code bytes behind an output register.
module mrle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          mark_byte,
	input  logic                head_valid,
	input  mrle_pkg::mrle_cmd_t head_cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          code_byte,
	output logic                last_of_burst,
	output logic                stream_done
);
	import mrle_pkg::*;

	typedef enum logic [3:0] {
		PH_MARK  = 4'b0001,
		PH_COUNT = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_LIT_B = 4'b1000
	} ph_t;

	mrle_cmd_t  wk_q;
	logic       wk_valid_q;
	ph_t        ph_q;
	ph_t        ph_next;
	logic       adv;
	logic       last;
	logic [7:0] sel_byte;
	logic       out_valid_q;
	logic [7:0] code_q;
	logic       last_q;
	logic       done_q;

	assign adv  = wk_valid_q && (!out_valid_q || out_ready);
	assign last = ((ph_q == PH_VALUE) && !wk_q.b_valid) || (ph_q == PH_LIT_B);
	assign pop  = head_valid && (!wk_valid_q || (adv && last));

	always_comb begin
		case (ph_q)
			PH_MARK: begin
				sel_byte = mark_byte;
				ph_next  = PH_COUNT;
			end
			PH_COUNT: begin
				sel_byte = wk_q.a_len + RUN_DIGIT_BASE;
				ph_next  = PH_VALUE;
			end
			PH_VALUE: begin
				sel_byte = wk_q.a_byte;
				ph_next  = PH_LIT_B;
			end
			PH_LIT_B: begin
				sel_byte = wk_q.b_byte;
				ph_next  = PH_MARK;
			end
			default: begin
				sel_byte = wk_q.a_byte;
				ph_next  = PH_MARK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wk_q <= head_cmd;
		end
		if (adv) begin
			code_q <= sel_byte;
			last_q <= last;
			done_q <= last && wk_q.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_valid_q  <= 1'b0;
			ph_q        <= PH_MARK;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				wk_valid_q <= 1'b1;
				ph_q       <= (head_cmd.a_len == 8'd1) ? PH_VALUE : PH_MARK;
			end else if (adv && last) begin
				wk_valid_q <= 1'b0;
			end else if (adv) begin
				ph_q <= ph_next;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign code_byte     = code_q;
	assign last_of_burst = last_q;
	assign stream_done   = done_q;

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stream_done) |-> last_of_burst)
		else $error("stream_done without last_of_burst");
	a_count_is_run: assert property (@(posedge clk) disable iff (!arst_n)
		(wk_valid_q && ph_q == PH_COUNT) |-> wk_q.a_len >= 8'd2)
		else $error("count digit for a single byte");
	a_lit_b_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(wk_valid_q && ph_q == PH_LIT_B) |-> wk_q.b_valid)
		else $error("trailing literal phase without literal");
`endif

endmodule

[rtl/marked_run_length_encoder.sv]
// Path: a code's first byte passes the command queue, work register and output register.
// Throughput: one input beat per cycle while the command queue has room; the back end
// emits one code byte per cycle while out_ready holds, so a flush of up to four bytes (code plus literal)
// sets the sustained rate on run-heavy input; beats that only extend a run cost nothing.
// Reset: arst_n clears the pending run, the queue and the output register at once;
// mark_byte returns to 42 and max_run to 207.
module marked_run_length_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mrle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_stream,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     code_byte,
	output logic                           last_of_burst,
	output logic                           stream_done
);
	import mrle_pkg::*;

	// configuration registers; writes beyond the list are dropped
	logic [7:0] mark_q;
	logic [7:0] max_run_q;

	// front to queue
	logic      push;
	mrle_cmd_t push_cmd;
	logic      q_full;

	// queue to back
	logic      head_valid;
	mrle_cmd_t head_cmd;
	logic      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q    <= MARK_RESET;
			max_run_q <= MAX_RUN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MARK:    mark_q    <= cfg_wdata;
				CFG_MAX_RUN: max_run_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// front: run tracking, one beat per cycle, stalls only when the queue is full
	mrle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.max_run       (max_run_q),
		.push          (push),
		.push_cmd      (push_cmd),
		.q_full        (q_full)
	);

	// short command queue decouples input stalls from output stalls
	mrle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back: mark / count digit / value sequencer plus trailing literal
	mrle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mark_byte     (mark_q),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_byte     (code_byte),
		.last_of_burst (last_of_burst),
		.stream_done   (stream_done)
	);

endmodule
